// ----- hw/rtl/assert_macros.svh -----
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge outside reset
`define TSKS_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define TSKS_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define TSKS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/tsks_pkg.sv -----
`default_nettype none
package tsks_pkg;

   localparam int KEY_COUNT_DEFAULT = 256;
   localparam int KEY_BYTES_DEFAULT = 32;
   localparam int QUEUE_DEPTH = 2;

   localparam int TW_N = 312;
   localparam int TW_M = 156;
   localparam logic [63:0] TW_INIT_MULT = 64'd6364136223846793005;
   localparam logic [63:0] TW_MATRIX = 64'hB502_6F5A_A966_19E9;
   localparam logic [63:0] TW_UPPER_MASK = 64'hFFFF_FFFF_8000_0000;
   localparam logic [63:0] TW_LOWER_MASK = 64'h0000_0000_7FFF_FFFF;
   localparam logic [63:0] FMIX_C1 = 64'hff51_afd7_ed55_8ccd;
   localparam logic [63:0] FMIX_C2 = 64'hc4ce_b9fe_1a85_ec53;
   localparam logic [31:0] SLOT_SECONDS_RESET = 32'd30;

   localparam logic [1:0] KIND_INIT = 2'd0;
   localparam logic [1:0] KIND_QUERY = 2'd1;
   localparam logic [1:0] KIND_TOLERANT = 2'd2;

   localparam logic [1:0] ST_KEY = 2'd0;
   localparam logic [1:0] ST_NOT_READY = 2'd1;
   localparam logic [1:0] ST_INIT_DONE = 2'd2;

   localparam logic [1:0] WHICH_CUR = 2'd0;
   localparam logic [1:0] WHICH_PREV = 2'd1;
   localparam logic [1:0] WHICH_NEXT = 2'd2;

   typedef enum logic [1:0] {
      OP_INIT = 2'd0,
      OP_QUERY = 2'd1,
      OP_TOLERANT = 2'd2
   } op_type;

   typedef struct packed {
      logic valid;
      op_type op;
      logic [63:0] payload;
   } q_item_type;

   typedef struct packed {
      logic start;
      logic [63:0] a;
      logic [63:0] b;
   } mul_req_type;

   typedef struct packed {
      logic done;
      logic busy;
      logic [63:0] result;
   } mul_rsp_type;

   typedef struct packed {
      logic start;
      logic [63:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic done;
      logic busy;
      logic [63:0] quotient;
      logic [31:0] remainder;
   } div_rsp_type;

   function automatic logic [63:0] tw_temper(input logic [63:0] y);
      logic [63:0] t;
      t = y ^ ((y >> 29) & 64'h5555_5555_5555_5555);
      t = t ^ ((t << 17) & 64'h71D6_7FFF_EDA6_0000);
      t = t ^ ((t << 37) & 64'hFFF7_EEE0_0000_0000);
      t = t ^ (t >> 43);
      return t;
   endfunction

   function automatic logic [63:0] mix33(input logic [63:0] x);
      return x ^ (x >> 33);
   endfunction

   function automatic logic [63:0] mix62(input logic [63:0] x);
      return x ^ (x >> 62);
   endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/time_slot_key_selector_unit.sv -----
`default_nettype none
// Time-slot key selector. An initialize word seeds a 64-bit Mersenne twister and fills a table
// of KEY_COUNT keys of KEY_BYTES bytes (one generator draw per byte), answering with one
// init-done word; the seeding runs through the multiplier, and the twister store is
// regenerated entry by entry whenever all of its entries have been drawn.
// A query divides the timestamp by slot_seconds (0 counts as 1), hashes the slot with the
// fmix64 finalizer and streams that key as 64-bit little-endian words; a tolerant query adds the
// previous slot's key (when the slot is above zero) and the next slot's key. A query first
// runs the slot division on a 64-step divider, then hashes each key with two passes through
// the one multiplier and reduces it to a table index by compare and subtract steps, then
// reads and sends the key words in turn, holding while the output stalls.
// A query before the first initialize gives one not-initialized word; kind 3 is dropped.
// Input words queue two deep and are taken while the back end works, until the queue is full.
module time_slot_key_selector_unit #(
   parameter int KEY_COUNT = tsks_pkg::KEY_COUNT_DEFAULT,
   parameter int KEY_BYTES = tsks_pkg::KEY_BYTES_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_kind,
   input  wire logic [63:0] req_seed,
   input  wire logic [63:0] req_timestamp,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [1:0]       rsp_which_key,
   output logic [1:0]       rsp_word_index,
   output logic [63:0]      rsp_key_word,
   output logic             rsp_last,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [31:0] csr_data
);
   import tsks_pkg::*;

   logic [31:0] slot_seconds_ff, slot_seconds_in;
   tsks_pkg::q_item_type head;
   logic pop;

   assign csr_ready = 1'b1;

   always_comb begin
      slot_seconds_in = slot_seconds_ff;
      if (csr_valid && csr_ready) begin
         slot_seconds_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_seconds_ff <= SLOT_SECONDS_RESET;
      end else begin
         slot_seconds_ff <= slot_seconds_in;
      end
   end

   tsks_front u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_kind(req_kind),
      .req_seed(req_seed),
      .req_timestamp(req_timestamp),
      .pop(pop),
      .head(head)
   );

   tsks_back #(
      .KEY_COUNT(KEY_COUNT),
      .KEY_BYTES(KEY_BYTES)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .head(head),
      .q_pop(pop),
      .slot_seconds(slot_seconds_ff),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_which_key(rsp_which_key),
      .rsp_word_index(rsp_word_index),
      .rsp_key_word(rsp_key_word),
      .rsp_last(rsp_last)
   );
endmodule
`default_nettype wire

// ----- hw/rtl/tsks_mul.sv -----
`default_nettype none
module tsks_mul (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire tsks_pkg::mul_req_type req,
   output tsks_pkg::mul_rsp_type      rsp
);
   import tsks_pkg::*;

   logic [63:0] a_ff, a_in;
   logic [63:0] b_ff, b_in;
   logic [63:0] acc_ff, acc_in;
   logic [1:0] step_ff, step_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [31:0] op_a, op_b;
   logic [63:0] prod;

   always_comb begin
      case (step_ff)
         2'd0: begin
            op_a = a_ff[31:0];
            op_b = b_ff[31:0];
         end
         2'd1: begin
            op_a = a_ff[63:32];
            op_b = b_ff[31:0];
         end
         default: begin
            op_a = a_ff[31:0];
            op_b = b_ff[63:32];
         end
      endcase
      prod = op_a * op_b;

      a_in = a_ff;
      b_in = b_ff;
      acc_in = acc_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         a_in = req.a;
         b_in = req.b;
         acc_in = '0;
         step_in = 2'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (step_ff == 2'd0) begin
            acc_in = prod;
         end else begin
            acc_in = acc_ff + {prod[31:0], 32'd0};
         end
         step_in = step_ff + 2'd1;
         if (step_ff == 2'd2) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      acc_ff <= acc_in;
      step_ff <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.busy = busy_ff;
   assign rsp.result = acc_ff;
endmodule
`default_nettype wire

// ----- hw/rtl/tsks_div.sv -----
`default_nettype none
module tsks_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire tsks_pkg::div_req_type req,
   output tsks_pkg::div_rsp_type      rsp
);
   import tsks_pkg::*;

   logic [63:0] q_ff, q_in;
   logic [31:0] r_ff, r_in;
   logic [31:0] d_ff, d_in;
   logic [5:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [32:0] shifted, diff;
   logic ge;

   always_comb begin
      shifted = {r_ff, q_ff[63]};
      diff = shifted - {1'b0, d_ff};
      ge = shifted >= {1'b0, d_ff};

      q_in = q_ff;
      r_in = r_ff;
      d_in = d_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         q_in = req.dividend;
         r_in = '0;
         d_in = req.divisor;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         q_in = {q_ff[62:0], ge};
         r_in = ge ? diff[31:0] : shifted[31:0];
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.busy = busy_ff;
   assign rsp.quotient = q_ff;
   assign rsp.remainder = r_ff;
endmodule
`default_nettype wire

// ----- hw/rtl/tsks_front.sv -----
`default_nettype none
module tsks_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [1:0]          req_kind,
   input  wire logic [63:0]         req_seed,
   input  wire logic [63:0]         req_timestamp,
   input  wire logic                pop,
   output tsks_pkg::q_item_type     head
);
   import tsks_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   op_type op_ff [QUEUE_DEPTH];
   logic [63:0] payload_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic accept, push;
   op_type op_class;
   logic [63:0] payload_class;

   always_comb begin
      req_stall = count_ff == CW'(QUEUE_DEPTH);
      accept = req_valid && !req_stall;
      push = accept && (req_kind == KIND_INIT || req_kind == KIND_QUERY ||
                        req_kind == KIND_TOLERANT);
      case (req_kind)
         KIND_INIT: op_class = OP_INIT;
         KIND_QUERY: op_class = OP_QUERY;
         default: op_class = OP_TOLERANT;
      endcase
      payload_class = (req_kind == KIND_INIT) ? req_seed : req_timestamp;

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         op_ff[wr_ptr_ff] <= op_class;
         payload_ff[wr_ptr_ff] <= payload_class;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   assign head.valid = count_ff != '0;
   assign head.op = op_ff[rd_ptr_ff];
   assign head.payload = payload_ff[rd_ptr_ff];
endmodule
`default_nettype wire

// ----- hw/rtl/tsks_back.sv -----
`default_nettype none
`include "assert_macros.svh"
module tsks_back #(
   parameter int KEY_COUNT = tsks_pkg::KEY_COUNT_DEFAULT,
   parameter int KEY_BYTES = tsks_pkg::KEY_BYTES_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire tsks_pkg::q_item_type head,
   output logic                     q_pop,
   input  wire logic [31:0]         slot_seconds,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [1:0]               rsp_status,
   output logic [1:0]               rsp_which_key,
   output logic [1:0]               rsp_word_index,
   output logic [63:0]              rsp_key_word,
   output logic                     rsp_last
);
   import tsks_pkg::*;

   localparam int WORDS_PER_KEY = (KEY_BYTES + 7) / 8;
   localparam int KEY_DEPTH = KEY_COUNT * WORDS_PER_KEY;
   localparam int KIW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
   localparam int KAW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
   localparam int WIW = (WORDS_PER_KEY > 1) ? $clog2(WORDS_PER_KEY) : 1;
   localparam int JW = $clog2(KEY_BYTES);
   localparam int TIW = $clog2(TW_N + 1);
   localparam logic [63:0] KC64 = 64'(KEY_COUNT);
   localparam logic [15:0] RED1 = 16'((64'd1 << 16) % KC64);
   localparam logic [15:0] RED2 = 16'((64'd1 << 32) % KC64);
   localparam logic [15:0] RED3 = 16'((64'd1 << 48) % KC64);
   localparam logic [33:0] DSH_START = 34'(KC64 << 17);
   localparam int RED_STEPS = 6;

   typedef enum logic [14:0] {
      B_IDLE    = 15'b000000000000001,
      B_SEED    = 15'b000000000000010,
      B_DRAW    = 15'b000000000000100,
      B_DRAW_RD = 15'b000000000001000,
      B_RG_A    = 15'b000000000010000,
      B_RG_B    = 15'b000000000100000,
      B_RG_C    = 15'b000000001000000,
      B_RG_D    = 15'b000000010000000,
      B_SLOT    = 15'b000000100000000,
      B_H1      = 15'b000001000000000,
      B_H2      = 15'b000010000000000,
      B_H3      = 15'b000100000000000,
      B_RD      = 15'b001000000000000,
      B_OUT     = 15'b010000000000000,
      B_RESP    = 15'b100000000000000
   } back_state_type;

   back_state_type state_ff, state_in;
   logic ready_ff, ready_in;
   logic [TIW-1:0] tw_pos_ff, tw_pos_in;
   logic [TIW-1:0] tw_i_ff, tw_i_in;
   logic [63:0] prev_ff, prev_in;
   logic [63:0] hold1_ff, hold1_in;
   logic [KIW-1:0] key_ff, key_in;
   logic [JW-1:0] byte_ff, byte_in;
   logic [KAW-1:0] kaddr_ff, kaddr_in;
   logic [63:0] acc_ff, acc_in;
   op_type op_ff, op_in;
   logic [63:0] slot_ff, slot_in;
   logic [1:0] which_ff, which_in;
   logic [KAW-1:0] base_ff, base_in;
   logic [WIW-1:0] w_ff, w_in;
   logic [1:0] resp_status_ff, resp_status_in;
   logic [33:0] red_ff, red_in;
   logic [33:0] dsh_ff, dsh_in;
   logic [2:0] rstep_ff, rstep_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic [1:0] rsp_which_ff, rsp_which_in;
   logic [1:0] rsp_index_ff, rsp_index_in;
   logic [63:0] rsp_word_ff, rsp_word_in;
   logic rsp_last_ff, rsp_last_in;

   logic [63:0] tw_mem [TW_N];
   logic [63:0] key_mem [KEY_DEPTH];
   logic [63:0] tw_rdata_ff;
   logic [63:0] key_rdata_ff;
   logic tw_we, key_we, key_re;
   logic [TIW-1:0] tw_waddr, tw_raddr;
   logic [63:0] tw_wdata, key_wdata;
   logic [KAW-1:0] key_waddr, key_raddr;

   tsks_pkg::mul_req_type mul_req;
   tsks_pkg::mul_rsp_type mul_rsp;
   tsks_pkg::div_req_type div_req;
   tsks_pkg::div_rsp_type div_rsp;

   logic out_free, rsp_load;
   logic [TIW-1:0] idx_next1, idx_m;
   logic [63:0] regen_x, regen_val, tempered, draw_acc, seed_val, next_h;
   logic word_end, key_end, table_end, word_last, final_key;
   logic [KIW-1:0] key_index;
   logic [63:0] hash_val;
   logic [33:0] red_fold, red_a, red_b, red_c;

   tsks_mul u_mul (
      .clock(clock),
      .reset(reset),
      .req(mul_req),
      .rsp(mul_rsp)
   );

   tsks_div u_div (
      .clock(clock),
      .reset(reset),
      .req(div_req),
      .rsp(div_rsp)
   );

   always_comb begin
      out_free = !rsp_valid_ff || !rsp_stall;
      idx_next1 = (tw_i_ff == TIW'(TW_N - 1)) ? '0 : tw_i_ff + TIW'(1);
      idx_m = (tw_i_ff >= TIW'(TW_N - TW_M)) ? tw_i_ff - TIW'(TW_N - TW_M)
                                              : tw_i_ff + TIW'(TW_M);
      regen_x = (prev_ff & TW_UPPER_MASK) | (hold1_ff & TW_LOWER_MASK);
      regen_val = tw_rdata_ff ^ (regen_x >> 1) ^ (regen_x[0] ? TW_MATRIX : 64'd0);
      tempered = tw_temper(tw_rdata_ff);
      draw_acc = acc_ff | (64'(tempered[7:0]) << {byte_ff[2:0], 3'b000});
      seed_val = mul_rsp.result + 64'(tw_i_ff);
      key_end = byte_ff == JW'(KEY_BYTES - 1);
      word_end = (byte_ff[2:0] == 3'd7) || key_end;
      table_end = key_end && (key_ff == KIW'(KEY_COUNT - 1));
      word_last = w_ff == WIW'(WORDS_PER_KEY - 1);
      final_key = (op_ff == OP_QUERY) || (which_ff == WHICH_NEXT);
      next_h = (which_ff == WHICH_CUR && slot_ff != 64'd0) ? slot_ff - 64'd1
                                                           : slot_ff + 64'd1;

      // fold 16-bit chunks by their weights mod key count
      hash_val = mix33(mul_rsp.result);
      red_fold = 34'(hash_val[15:0]) + 34'(hash_val[31:16]) * 34'(RED1) +
                 34'(hash_val[47:32]) * 34'(RED2) + 34'(hash_val[63:48]) * 34'(RED3);
      red_a = (red_ff >= dsh_ff) ? red_ff - dsh_ff : red_ff;
      red_b = (red_a >= (dsh_ff >> 1)) ? red_a - (dsh_ff >> 1) : red_a;
      red_c = (red_b >= (dsh_ff >> 2)) ? red_b - (dsh_ff >> 2) : red_b;
      key_index = KIW'(red_c);

      state_in = state_ff;
      ready_in = ready_ff;
      tw_pos_in = tw_pos_ff;
      tw_i_in = tw_i_ff;
      prev_in = prev_ff;
      hold1_in = hold1_ff;
      key_in = key_ff;
      byte_in = byte_ff;
      kaddr_in = kaddr_ff;
      acc_in = acc_ff;
      op_in = op_ff;
      slot_in = slot_ff;
      which_in = which_ff;
      base_in = base_ff;
      w_in = w_ff;
      resp_status_in = resp_status_ff;
      red_in = red_ff;
      dsh_in = dsh_ff;
      rstep_in = rstep_ff;

      rsp_load = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_which_in = rsp_which_ff;
      rsp_index_in = rsp_index_ff;
      rsp_word_in = rsp_word_ff;
      rsp_last_in = rsp_last_ff;

      q_pop = 1'b0;
      tw_we = 1'b0;
      tw_waddr = tw_i_ff;
      tw_wdata = regen_val;
      tw_raddr = tw_pos_ff;
      key_we = 1'b0;
      key_waddr = kaddr_ff;
      key_wdata = draw_acc;
      key_re = 1'b0;
      key_raddr = base_ff + KAW'(w_ff);
      mul_req = '0;
      div_req = '0;

      case (state_ff)
         B_IDLE: begin
            if (head.valid) begin
               q_pop = 1'b1;
               op_in = head.op;
               if (head.op == OP_INIT) begin
                  tw_we = 1'b1;
                  tw_waddr = '0;
                  tw_wdata = head.payload;
                  prev_in = head.payload;
                  tw_i_in = TIW'(1);
                  mul_req.start = 1'b1;
                  mul_req.a = mix62(head.payload);
                  mul_req.b = TW_INIT_MULT;
                  state_in = B_SEED;
               end else if (!ready_ff) begin
                  resp_status_in = ST_NOT_READY;
                  state_in = B_RESP;
               end else begin
                  div_req.start = 1'b1;
                  div_req.dividend = head.payload;
                  div_req.divisor = (slot_seconds == 32'd0) ? 32'd1 : slot_seconds;
                  state_in = B_SLOT;
               end
            end
         end
         B_SEED: begin
            if (mul_rsp.done) begin
               tw_we = 1'b1;
               tw_waddr = tw_i_ff;
               tw_wdata = seed_val;
               if (tw_i_ff == TIW'(TW_N - 1)) begin
                  tw_pos_in = TIW'(TW_N);
                  key_in = '0;
                  byte_in = '0;
                  kaddr_in = '0;
                  acc_in = '0;
                  state_in = B_DRAW;
               end else begin
                  tw_i_in = tw_i_ff + TIW'(1);
                  mul_req.start = 1'b1;
                  mul_req.a = mix62(seed_val);
                  mul_req.b = TW_INIT_MULT;
               end
            end
         end
         B_DRAW: begin
            if (tw_pos_ff == TIW'(TW_N)) begin
               tw_i_in = '0;
               state_in = B_RG_A;
            end else begin
               tw_raddr = tw_pos_ff;
               state_in = B_DRAW_RD;
            end
         end
         B_DRAW_RD: begin
            tw_pos_in = tw_pos_ff + TIW'(1);
            if (word_end) begin
               key_we = 1'b1;
               kaddr_in = kaddr_ff + KAW'(1);
               acc_in = '0;
            end else begin
               acc_in = draw_acc;
            end
            if (key_end) begin
               byte_in = '0;
               key_in = key_ff + KIW'(1);
            end else begin
               byte_in = byte_ff + JW'(1);
            end
            if (table_end) begin
               ready_in = 1'b1;
               resp_status_in = ST_INIT_DONE;
               state_in = B_RESP;
            end else begin
               state_in = B_DRAW;
            end
         end
         B_RG_A: begin
            tw_raddr = tw_i_ff;
            state_in = B_RG_B;
         end
         B_RG_B: begin
            prev_in = tw_rdata_ff;
            tw_raddr = idx_next1;
            state_in = B_RG_C;
         end
         B_RG_C: begin
            hold1_in = tw_rdata_ff;
            tw_raddr = idx_m;
            state_in = B_RG_D;
         end
         B_RG_D: begin
            tw_we = 1'b1;
            if (tw_i_ff == TIW'(TW_N - 1)) begin
               tw_pos_in = '0;
               state_in = B_DRAW;
            end else begin
               tw_i_in = tw_i_ff + TIW'(1);
               state_in = B_RG_A;
            end
         end
         B_SLOT: begin
            if (div_rsp.done) begin
               slot_in = div_rsp.quotient;
               which_in = WHICH_CUR;
               mul_req.start = 1'b1;
               mul_req.a = mix33(div_rsp.quotient);
               mul_req.b = FMIX_C1;
               state_in = B_H1;
            end
         end
         B_H1: begin
            if (mul_rsp.done) begin
               mul_req.start = 1'b1;
               mul_req.a = mix33(mul_rsp.result);
               mul_req.b = FMIX_C2;
               state_in = B_H2;
            end
         end
         B_H2: begin
            if (mul_rsp.done) begin
               red_in = red_fold;
               dsh_in = DSH_START;
               rstep_in = '0;
               state_in = B_H3;
            end
         end
         B_H3: begin
            // three compare and subtract steps per cycle
            red_in = red_c;
            dsh_in = dsh_ff >> 3;
            rstep_in = rstep_ff + 3'd1;
            if (rstep_ff == 3'(RED_STEPS - 1)) begin
               base_in = KAW'(key_index * WORDS_PER_KEY);
               w_in = '0;
               state_in = B_RD;
            end
         end
         B_RD: begin
            key_re = 1'b1;
            state_in = B_OUT;
         end
         B_OUT: begin
            if (out_free) begin
               rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_status_in = ST_KEY;
               rsp_which_in = which_ff;
               rsp_index_in = 2'(w_ff);
               rsp_word_in = key_rdata_ff;
               rsp_last_in = word_last && final_key;
               if (!word_last) begin
                  w_in = w_ff + WIW'(1);
                  state_in = B_RD;
               end else if (final_key) begin
                  state_in = B_IDLE;
               end else begin
                  which_in = (which_ff == WHICH_CUR && slot_ff != 64'd0) ? WHICH_PREV
                                                                         : WHICH_NEXT;
                  mul_req.start = 1'b1;
                  mul_req.a = mix33(next_h);
                  mul_req.b = FMIX_C1;
                  state_in = B_H1;
               end
            end
         end
         B_RESP: begin
            if (out_free) begin
               rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_status_in = resp_status_ff;
               rsp_which_in = WHICH_CUR;
               rsp_index_in = '0;
               rsp_word_in = '0;
               rsp_last_in = 1'b1;
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (tw_we) begin
         tw_mem[tw_waddr] <= tw_wdata;
      end
      tw_rdata_ff <= tw_mem[tw_raddr];
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[key_waddr] <= key_wdata;
      end
      if (key_re) begin
         key_rdata_ff <= key_mem[key_raddr];
      end
   end

   always_ff @(posedge clock) begin
      tw_i_ff <= tw_i_in;
      prev_ff <= prev_in;
      hold1_ff <= hold1_in;
      key_ff <= key_in;
      byte_ff <= byte_in;
      kaddr_ff <= kaddr_in;
      acc_ff <= acc_in;
      op_ff <= op_in;
      slot_ff <= slot_in;
      which_ff <= which_in;
      base_ff <= base_in;
      w_ff <= w_in;
      resp_status_ff <= resp_status_in;
      red_ff <= red_in;
      dsh_ff <= dsh_in;
      rstep_ff <= rstep_in;
      rsp_status_ff <= rsp_status_in;
      rsp_which_ff <= rsp_which_in;
      rsp_index_ff <= rsp_index_in;
      rsp_word_ff <= rsp_word_in;
      rsp_last_ff <= rsp_last_in;
      if (reset) begin
         state_ff <= B_IDLE;
         ready_ff <= 1'b0;
         tw_pos_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
         tw_pos_ff <= tw_pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_which_key = rsp_which_ff;
   assign rsp_word_index = rsp_index_ff;
   assign rsp_key_word = rsp_word_ff;
   assign rsp_last = rsp_last_ff;

   `TSKS_ASSERT_IMPLY(a_pop_idle, clock, reset, q_pop, state_ff == B_IDLE && head.valid, "pop outside idle")
   `TSKS_ASSERT_IMPLY(a_load_free, clock, reset, rsp_load, out_free, "result word overwritten")
   `TSKS_ASSERT_IMPLY(a_mul_idle, clock, reset, mul_req.start, !mul_rsp.busy, "multiplier restarted")
   `TSKS_ASSERT_ALWAYS(a_pos_range, clock, reset, tw_pos_ff <= TIW'(TW_N), "twister position out of range")
   `TSKS_ASSERT_NEXT(a_ready_set, clock, reset, state_ff == B_DRAW_RD && table_end, ready_ff && state_ff == B_RESP, "ready not set after table fill")
endmodule
`default_nettype wire
